[rtl/assert_macros.svh]
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that a condition implies a property at the same clock edge.
`define ASSERT_IMPLY(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

`endif

[rtl/deq_pkg.sv]
`default_nettype none

package deq_pkg;

   localparam int DEPTH   = 1024;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int COUNT_W = 11;
   localparam int WORD_W  = 32;

   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_CLEAR      = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]               op;
      logic signed [WORD_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] popped_value;
      logic signed [WORD_W-1:0] front_value;
      logic signed [WORD_W-1:0] back_value;
      logic [COUNT_W-1:0]       count;
      logic [1:0]               status;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/double_ended_queue.sv]
`default_nettype none
// Double-ended queue of 1024 signed 32-bit words in a circular store.
// A request word on the req_ channel carries an operation (push front, push
// back, pop front, pop back, clear) and a value to push. Every request gives
// exactly one response word on the rsp_ channel with the popped word, the
// front and back words after the operation, the count and a status.
// Pops on an empty queue and pushes into a full queue are refused with an
// error status and leave the queue unchanged.
// A request passes the middle stage and then the response register; one
// request is accepted every cycle unless the receiver stalls. The front
// and back words are kept in registers; a pop reads the next end word
// from the single-port store in the acceptance cycle, and that registered
// read is merged when the response is formed.
// Synchronous reset empties the queue and drops any word in flight; the
// store contents are not cleared; unheld words read never reach a response.
// When the receiver stalls, the response register holds its word, one more
// request may be accepted into the middle stage, and then req_ready drops.

module double_ended_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire deq_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output deq_pkg::rsp_type      rsp_data
);
   import deq_pkg::*;

   logic [WORD_W-1:0]  mem [DEPTH];
   logic [WORD_W-1:0]  rd_data_ff;

   logic [IDX_W-1:0]   front_idx_ff, front_idx_in;
   logic [IDX_W-1:0]   back_idx_ff, back_idx_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [WORD_W-1:0]  front_word_ff, front_word_in;
   logic [WORD_W-1:0]  back_word_ff, back_word_in;
   logic               fix_front_ff, fix_front_in;
   logic               fix_back_ff, fix_back_in;

   logic               s1_valid_ff;
   logic [WORD_W-1:0]  s1_popped_ff, s1_popped_in;
   logic [1:0]         s1_status_ff, s1_status_in;
   logic [COUNT_W-1:0] s1_count_ff;

   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               accept;
   logic               s1_move;
   logic               full;
   logic               empty;
   logic [WORD_W-1:0]  front_eff;
   logic [WORD_W-1:0]  back_eff;
   logic               mem_we, mem_re;
   logic [IDX_W-1:0]   wr_addr, rd_addr;
   logic [IDX_W-1:0]   idx_span;

   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;
   assign accept    = req_valid && req_ready;

   assign front_eff = fix_front_ff ? rd_data_ff : front_word_ff;
   assign back_eff  = fix_back_ff ? rd_data_ff : back_word_ff;
   assign full      = count_ff == COUNT_W'(DEPTH);
   assign empty     = count_ff == '0;

   always_comb begin
      front_idx_in  = front_idx_ff;
      back_idx_in   = back_idx_ff;
      count_in      = count_ff;
      front_word_in = front_eff;
      back_word_in  = back_eff;
      fix_front_in  = 1'b0;
      fix_back_in   = 1'b0;
      s1_popped_in  = '0;
      s1_status_in  = ST_OK;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      wr_addr       = back_idx_ff;
      rd_addr       = front_idx_ff + IDX_W'(1);
      case (req_data.op)
         OP_PUSH_FRONT: begin
            if (full) begin
               s1_status_in = ST_FULL;
            end else begin
               wr_addr       = front_idx_ff - IDX_W'(1);
               front_idx_in  = front_idx_ff - IDX_W'(1);
               mem_we        = 1'b1;
               front_word_in = req_data.value;
               if (empty) begin
                  back_word_in = req_data.value;
               end
               count_in = count_ff + COUNT_W'(1);
            end
         end
         OP_PUSH_BACK: begin
            if (full) begin
               s1_status_in = ST_FULL;
            end else begin
               wr_addr      = back_idx_ff;
               back_idx_in  = back_idx_ff + IDX_W'(1);
               mem_we       = 1'b1;
               back_word_in = req_data.value;
               if (empty) begin
                  front_word_in = req_data.value;
               end
               count_in = count_ff + COUNT_W'(1);
            end
         end
         OP_POP_FRONT: begin
            if (empty) begin
               s1_status_in = ST_EMPTY;
            end else begin
               s1_popped_in = front_eff;
               front_idx_in = front_idx_ff + IDX_W'(1);
               rd_addr      = front_idx_ff + IDX_W'(1);
               mem_re       = 1'b1;
               fix_front_in = 1'b1;
               count_in     = count_ff - COUNT_W'(1);
            end
         end
         OP_POP_BACK: begin
            if (empty) begin
               s1_status_in = ST_EMPTY;
            end else begin
               s1_popped_in = back_eff;
               back_idx_in  = back_idx_ff - IDX_W'(1);
               rd_addr      = back_idx_ff - IDX_W'(2);
               mem_re       = 1'b1;
               fix_back_in  = 1'b1;
               count_in     = count_ff - COUNT_W'(1);
            end
         end
         OP_CLEAR: begin
            front_idx_in = '0;
            back_idx_in  = '0;
            count_in     = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept && mem_we) begin
         mem[wr_addr] <= req_data.value;
      end
      if (accept && mem_re) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_idx_ff <= '0;
         back_idx_ff  <= '0;
         count_ff     <= '0;
         fix_front_ff <= 1'b0;
         fix_back_ff  <= 1'b0;
      end else if (accept) begin
         front_idx_ff <= front_idx_in;
         back_idx_ff  <= back_idx_in;
         count_ff     <= count_in;
         fix_front_ff <= fix_front_in;
         fix_back_ff  <= fix_back_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         front_word_ff <= front_word_in;
         back_word_ff  <= back_word_in;
         s1_popped_ff  <= s1_popped_in;
         s1_status_ff  <= s1_status_in;
         s1_count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      rsp_data_in.popped_value = s1_popped_ff;
      rsp_data_in.count        = s1_count_ff;
      rsp_data_in.status       = s1_status_ff;
      if (s1_count_ff == '0) begin
         rsp_data_in.front_value = '0;
         rsp_data_in.back_value  = '0;
      end else begin
         rsp_data_in.front_value = front_eff;
         rsp_data_in.back_value  = back_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign idx_span = back_idx_ff - front_idx_ff;

`include "assert_macros.svh"

   `ASSERT_CLK(a_count_bound, count_ff <= COUNT_W'(DEPTH), "count exceeds depth")
   `ASSERT_CLK(a_one_fix, $onehot0({fix_front_ff, fix_back_ff}), "two end words pending")
   `ASSERT_CLK(a_span, idx_span == count_ff[IDX_W-1:0], "end pointers disagree with count")
   `ASSERT_IMPLY(a_stall_block, s1_valid_ff && rsp_valid_ff && !rsp_ready, !req_ready,
      "request taken while pipeline is stalled")

endmodule

`default_nettype wire
